// ----- design/fpfc_pkg.sv -----
// Shared types and constants for the framebuffer to panel format converter.
// Used by the lane, address unit, top level and the checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fpfc_pkg;

  // Panel geometry
  localparam int MONO_COLUMNS = 132;
  localparam int MONO_PAGES   = 8;
  localparam int GRAY_SIDE    = 64;
  localparam int MAX_WIDTH    = 1024;

  // Field widths
  localparam int PIX_W   = 8;
  localparam int IDX_W   = 10;
  localparam int DIM_W   = 11;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 20;
  localparam int CFG_W   = 11;
  localparam int LANES   = 8;
  // address math keeps one extra bit for the mode 3 halving
  localparam int SUM_W   = ADDR_W + 1;

  localparam logic [PIX_W-1:0]  MONO_THRESHOLD = 8'd108;
  localparam logic [DATA_W-1:0] RGB_KEEP_MASK  = 32'hE007E007;
  localparam logic [DATA_W-1:0] RGB_RED_MASK   = 32'h1F001F00;
  localparam logic [DATA_W-1:0] RGB_BLUE_MASK  = 32'h00F800F8;

  typedef enum logic [1:0] {
    MODE_MONO  = 2'd0,
    MODE_GRAY4 = 2'd1,
    MODE_GRAY8 = 2'd2,
    MODE_RGB   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    CFG_MODE   = 3'd0,
    CFG_FLIP   = 3'd1,
    CFG_INVERT = 3'd2,
    CFG_WIDTH  = 3'd3,
    CFG_HEIGHT = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix0;
    logic [PIX_W-1:0] pix1;
    logic [PIX_W-1:0] pix2;
    logic [PIX_W-1:0] pix3;
    logic [PIX_W-1:0] pix4;
    logic [PIX_W-1:0] pix5;
    logic [PIX_W-1:0] pix6;
    logic [PIX_W-1:0] pix7;
    logic [IDX_W-1:0] column;
    logic [IDX_W-1:0] row;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [ADDR_W-1:0] address;
  } out_item_t;

  // Settings the address unit needs, grouped
  typedef struct packed {
    mode_t            mode;
    logic             flip;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } addr_cfg_t;

endpackage

`default_nettype wire

// ----- design/fpfc_lane.sv -----
// One pixel lane: threshold compare for mono page packing, with inversion.
// Depends on fpfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpfc_lane (
  input  wire logic [fpfc_pkg::PIX_W-1:0] pix,
  input  wire logic                       inv_bit,
  output logic                            mono_bit
);
  import fpfc_pkg::*;

  // lit when at or above threshold, then flipped by the invert mask bit
  assign mono_bit = (pix >= MONO_THRESHOLD) ^ inv_bit;

endmodule

`default_nettype wire

// ----- design/fpfc_addr.sv -----
// Destination address unit: row * stride + column, with optional mirroring.
// Depends on fpfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpfc_addr (
  input  wire fpfc_pkg::addr_cfg_t        cfg,
  input  wire logic [fpfc_pkg::IDX_W-1:0] row,
  input  wire logic [fpfc_pkg::IDX_W-1:0] column,
  output logic [fpfc_pkg::ADDR_W-1:0]     address
);
  import fpfc_pkg::*;

  logic [SUM_W-1:0] row_term;
  logic [SUM_W-1:0] stride;
  logic [SUM_W-1:0] col_term;
  logic [SUM_W-1:0] row_ext;
  logic [SUM_W-1:0] col_ext;
  logic [SUM_W-1:0] prod;
  logic [SUM_W-1:0] sum;

  assign row_ext = SUM_W'(row);
  assign col_ext = SUM_W'(column);

  // Pick factors per mode; mirrored terms wrap modulo the sum width
  always_comb begin
    row_term = row_ext;
    stride   = SUM_W'(cfg.width);
    col_term = col_ext;
    case (cfg.mode)
      MODE_MONO: begin
        stride = SUM_W'(MONO_COLUMNS);
        if (cfg.flip) begin
          row_term = SUM_W'(MONO_PAGES - 1) - row_ext;
          col_term = SUM_W'(MONO_COLUMNS - 1) - col_ext;
        end
      end
      MODE_GRAY4: begin
        stride = SUM_W'(GRAY_SIDE);
        if (cfg.flip) begin
          row_term = SUM_W'(GRAY_SIDE - 1) - row_ext;
          col_term = SUM_W'(GRAY_SIDE - 1) - col_ext;
        end
      end
      MODE_GRAY8: begin
        if (cfg.flip) begin
          row_term = SUM_W'(cfg.height) - SUM_W'(1) - row_ext;
          col_term = SUM_W'(cfg.width) - SUM_W'(1) - col_ext;
        end
      end
      MODE_RGB: begin
        col_term = {col_ext[SUM_W-2:0], 1'b0};
      end
      default: begin
        row_term = row_ext;
      end
    endcase
  end

  assign prod = row_term * stride;
  assign sum  = prod + col_term;

  // mode 3 gives a word index: pixel offset halved
  assign address = (cfg.mode == MODE_RGB) ? sum[SUM_W-1:1] : sum[ADDR_W-1:0];

endmodule

`default_nettype wire

// ----- design/framebuffer_to_panel_format_converter.sv -----
// Each input transfer passes through the compute stage, then the output
// register, to reach out_item. Throughput: one item per cycle while out_stall
// is low; eight pixel lanes run side by side and the address multiply-add
// settles within the compute stage. Input stalls only while both stages are
// full and the output is stalled. Reset (rst_n low, synchronous) empties the
// pipeline and sets mode 0, no flip, no invert, width 400, height 240.
`timescale 1ns / 1ps
`default_nettype none

module framebuffer_to_panel_format_converter (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [2:0]                 cfg_index,
  input  wire logic [fpfc_pkg::CFG_W-1:0] cfg_wdata,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire fpfc_pkg::in_item_t         in_item,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output fpfc_pkg::out_item_t             out_item
);
  import fpfc_pkg::*;

  // Configuration registers
  mode_t            mode_r;
  logic             flip_r;
  logic [7:0]       invert_r;
  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_MONO;
      flip_r   <= 1'b0;
      invert_r <= 8'd0;
      width_r  <= DIM_W'(400);
      height_r <= DIM_W'(240);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MODE:   mode_r   <= mode_t'(cfg_wdata[1:0]);
        CFG_FLIP:   flip_r   <= cfg_wdata[0];
        CFG_INVERT: invert_r <= cfg_wdata[7:0];
        CFG_WIDTH:  width_r  <= cfg_wdata[DIM_W-1:0];
        CFG_HEIGHT: height_r <= cfg_wdata[DIM_W-1:0];
        default:    ;
      endcase
    end
  end

  // Clamp frame dimensions to 1..MAX_WIDTH
  logic [DIM_W-1:0] width_sat;
  logic [DIM_W-1:0] height_sat;

  always_comb begin
    width_sat = width_r;
    if (width_r == '0) width_sat = DIM_W'(1);
    else if (width_r > DIM_W'(MAX_WIDTH)) width_sat = DIM_W'(MAX_WIDTH);
    height_sat = height_r;
    if (height_r == '0) height_sat = DIM_W'(1);
    else if (height_r > DIM_W'(MAX_WIDTH)) height_sat = DIM_W'(MAX_WIDTH);
  end

  // Pixel lanes
  logic [PIX_W-1:0] pix_a [LANES];
  logic [LANES-1:0] mono_bits;

  assign pix_a[0] = in_item.pix0;
  assign pix_a[1] = in_item.pix1;
  assign pix_a[2] = in_item.pix2;
  assign pix_a[3] = in_item.pix3;
  assign pix_a[4] = in_item.pix4;
  assign pix_a[5] = in_item.pix5;
  assign pix_a[6] = in_item.pix6;
  assign pix_a[7] = in_item.pix7;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    fpfc_lane u_lane (
      .pix      (pix_a[g]),
      .inv_bit  (invert_r[g]),
      .mono_bit (mono_bits[g])
    );
  end

  // Address unit
  addr_cfg_t         addr_cfg;
  logic [ADDR_W-1:0] addr_c;

  assign addr_cfg = '{mode: mode_r, flip: flip_r, width: width_sat, height: height_sat};

  fpfc_addr u_addr (
    .cfg     (addr_cfg),
    .row     (in_item.row),
    .column  (in_item.column),
    .address (addr_c)
  );

  // Merge lane results into the panel data word
  logic [7:0]        mono_rev;
  logic [7:0]        gray4;
  logic [DATA_W-1:0] rgb_word;
  logic [DATA_W-1:0] data_c;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      mono_rev[i] = mono_bits[LANES-1-i];
    end
    gray4 = {in_item.pix0[7:4], in_item.pix1[7:4]};
    if (invert_r != 8'd0) gray4 = ~gray4;
    rgb_word = {in_item.pix3, in_item.pix2, in_item.pix1, in_item.pix0};
    case (mode_r)
      MODE_MONO:  data_c = {24'd0, flip_r ? mono_rev : mono_bits};
      MODE_GRAY4: data_c = {24'd0, flip_r ? {gray4[3:0], gray4[7:4]} : gray4};
      MODE_GRAY8: data_c = {24'd0, in_item.pix0 ^ invert_r};
      MODE_RGB:   data_c = (rgb_word & RGB_KEEP_MASK)
                         | ((rgb_word & RGB_RED_MASK) >> 5)
                         | ((rgb_word & RGB_BLUE_MASK) << 5);
      default:    data_c = '0;
    endcase
  end

  // Two-stage pipeline: compute stage then output register
  logic      s1_valid_r;
  out_item_t s1_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  logic      s2_ready;
  logic      s1_ready;

  assign s2_ready = !out_valid_r || !out_stall;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_stall = !s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_r <= in_valid;
      if (s2_ready) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_item_r.data    <= data_c;
      s1_item_r.address <= addr_c;
    end
    if (s2_ready && s1_valid_r) out_item_r <= s1_item_r;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// ----- design/fpfc_checker.sv -----
// Port-level checker for the format converter, bound to the top level.
// Depends on fpfc_pkg and framebuffer_to_panel_format_converter.
`timescale 1ns / 1ps
`default_nettype none

module fpfc_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       cfg_we,
  input wire logic [2:0]                 cfg_index,
  input wire logic [fpfc_pkg::CFG_W-1:0] cfg_wdata,
  input wire logic                       in_valid,
  input wire logic                       in_stall,
  input wire fpfc_pkg::in_item_t         in_item,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire fpfc_pkg::out_item_t        out_item
);
  import fpfc_pkg::*;

  // Shadow of the mode register, tracked from the write port
  logic [1:0] mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_MONO;
    end else if (cfg_we && cfg_index == CFG_MODE) begin
      mode_r <= cfg_wdata[1:0];
    end
  end

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // Stalled input transfer keeps its payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_item))
    else $error("stalled input changed");

  // Pipeline empties on reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Input backs up only behind a waiting result
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

  // Byte modes leave the upper data bits clear
  a_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && mode_r != MODE_RGB && !cfg_we |-> out_item.data[31:8] == 24'd0)
    else $error("byte mode result has upper bits set");

endmodule

bind framebuffer_to_panel_format_converter fpfc_checker u_fpfc_checker (.*);

`default_nettype wire
